FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the distance constraint relax RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define DCR_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define DCR_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

FILE: hw/rtl/dcr_pkg.sv
// Shared types and constants for the distance constraint relax block.
// No dependencies; imported by every module of the block.
`default_nettype none

package dcr_pkg;

  localparam int LIMIT_W   = 33;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_SHORT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG  = 1'd1;

  localparam int CASE_W = 2;
  localparam logic [CASE_W-1:0] CASE_BAND  = 2'd0;
  localparam logic [CASE_W-1:0] CASE_SHORT = 2'd1;
  localparam logic [CASE_W-1:0] CASE_LONG  = 2'd2;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;

  // kind of correction and whether each axis move is subtracted from b
  typedef struct packed {
    logic [CASE_W-1:0] kind;
    logic              neg_x;
    logic              neg_y;
  } ctl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/dcr_front.sv
// Front pipeline: deltas, squared length, band classification, dividend set-up.
// Depends on dcr_pkg.
`default_nettype none

module dcr_front #(
  parameter int CW = 16,
  parameter int F  = 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic [CW-1:0]             a_x_i,
  input  wire logic [CW-1:0]             a_y_i,
  input  wire logic [CW-1:0]             b_x_i,
  input  wire logic [CW-1:0]             b_y_i,
  input  wire logic [dcr_pkg::LIMIT_W-1:0] short_i,
  input  wire logic [dcr_pkg::LIMIT_W-1:0] long_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic [4*CW-1:0]                crd_o,
  output logic [2*CW-1:0]                mag_o,
  output logic [((2*CW+1 > dcr_pkg::LIMIT_W) ? 2*CW+1 : dcr_pkg::LIMIT_W)+F:0] num_o,
  output logic [((2*CW+1 > dcr_pkg::LIMIT_W) ? 2*CW+1 : dcr_pkg::LIMIT_W)+1:0] den_o,
  output dcr_pkg::ctl_t                  ctl_o
);
  import dcr_pkg::*;

  localparam int SW = (2*CW+1 > LIMIT_W) ? 2*CW+1 : LIMIT_W;
  localparam int NW = SW + F + 1;
  localparam int DW = SW + 2;

  logic          en;
  logic [4:0]    v_r;

  logic [4*CW-1:0] crd1_r, crd2_r, crd3_r, crd4_r, crd5_r;
  logic [CW:0]     dx1_r, dy1_r;
  logic [CW:0]     nx_c, ny_c;
  logic [2*CW-1:0] mag2_r, mag3_r, mag4_r, mag5_r;
  logic [1:0]      sg2_r, sg3_r, sg4_r;
  logic [2*CW-1:0] sqx2_r, sqy2_r;
  logic [SW-1:0]   d3_r;
  logic [SW-1:0]   ls_c, lg_c;
  logic            lt_c, gt_c;
  logic [CASE_W-1:0] kind_c, kind4_r;
  logic [SW-1:0]   num_c, num4_r;
  logic [SW:0]     sum_c, sum4_r;
  logic [NW-1:0]   num5_r;
  logic [DW-1:0]   den5_r;
  ctl_t            ctl5_r;

  assign en         = !v_r[4] || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[3:0], in_valid_i};
    end
  end

  always_comb begin
    nx_c = dx1_r[CW] ? (~dx1_r + 1'b1) : dx1_r;
    ny_c = dy1_r[CW] ? (~dy1_r + 1'b1) : dy1_r;
  end

  always_comb begin
    ls_c = SW'(short_i);
    lg_c = SW'(long_i);
    lt_c = d3_r < ls_c;
    gt_c = d3_r > lg_c;
    priority if (lt_c) begin
      kind_c = CASE_SHORT;
    end else if (gt_c) begin
      kind_c = CASE_LONG;
    end else begin
      kind_c = CASE_BAND;
    end
    num_c = lt_c ? (ls_c - d3_r) : (d3_r - lg_c);
    sum_c = lt_c ? ((SW+1)'(d3_r) + (SW+1)'(ls_c)) : ((SW+1)'(d3_r) + (SW+1)'(lg_c));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      crd1_r <= {b_y_i, b_x_i, a_y_i, a_x_i};
      dx1_r  <= {b_x_i[CW-1], b_x_i} - {a_x_i[CW-1], a_x_i};
      dy1_r  <= {b_y_i[CW-1], b_y_i} - {a_y_i[CW-1], a_y_i};

      crd2_r <= crd1_r;
      mag2_r <= {ny_c[CW-1:0], nx_c[CW-1:0]};
      sg2_r  <= {dy1_r[CW], dx1_r[CW]};
      sqx2_r <= (2*CW)'(nx_c[CW-1:0]) * (2*CW)'(nx_c[CW-1:0]);
      sqy2_r <= (2*CW)'(ny_c[CW-1:0]) * (2*CW)'(ny_c[CW-1:0]);

      crd3_r <= crd2_r;
      mag3_r <= mag2_r;
      sg3_r  <= sg2_r;
      d3_r   <= SW'(sqx2_r) + SW'(sqy2_r);

      crd4_r  <= crd3_r;
      mag4_r  <= mag3_r;
      sg4_r   <= sg3_r;
      kind4_r <= kind_c;
      num4_r  <= num_c;
      sum4_r  <= sum_c;

      crd5_r       <= crd4_r;
      mag5_r       <= mag4_r;
      num5_r       <= (NW'(num4_r) << F) + NW'(sum4_r);
      den5_r       <= {sum4_r, 1'b0};
      ctl5_r.kind  <= kind4_r;
      ctl5_r.neg_x <= (kind4_r == CASE_LONG) ^ sg4_r[0];
      ctl5_r.neg_y <= (kind4_r == CASE_LONG) ^ sg4_r[1];
    end
  end

  assign out_valid_o = v_r[4];
  assign crd_o       = crd5_r;
  assign mag_o       = mag5_r;
  assign num_o       = num5_r;
  assign den_o       = den5_r;
  assign ctl_o       = ctl5_r;

endmodule

`default_nettype wire

FILE: hw/rtl/dcr_queue.sv
// Short register queue between the front and back pipelines.
// Depends on dcr_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module dcr_queue #(
  parameter int W = 8
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push_i,
  input  wire logic [W-1:0] data_i,
  input  wire logic         pop_i,
  output logic [W-1:0]      data_o,
  output logic              full_o,
  output logic              empty_o
);
  import dcr_pkg::*;

  logic [W-1:0]    mem_r [0:Q_DEPTH-1];
  logic [Q_AW-1:0] wr_r, rd_r;
  logic [Q_AW:0]   cnt_r;

  assign full_o  = cnt_r == (Q_AW+1)'(Q_DEPTH);
  assign empty_o = cnt_r == '0;
  assign data_o  = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push_i) begin
        wr_r <= wr_r + 1'b1;
      end
      if (pop_i) begin
        rd_r <= rd_r + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) begin
      mem_r[wr_r] <= data_i;
    end
  end

  `DCR_NEVER(a_no_overflow, clk, rst_n, push_i && full_o, "queue push while full")
  `DCR_NEVER(a_no_underflow, clk, rst_n, pop_i && empty_o, "queue pop while empty")

endmodule

`default_nettype wire

FILE: hw/rtl/dcr_back.sv
// Back pipeline: restoring divider one quotient bit per stage, scaled move, saturation.
// Depends on dcr_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module dcr_back #(
  parameter int CW = 16,
  parameter int F  = 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid_i,
  output logic                           pop_o,
  input  wire logic [4*CW-1:0]           crd_i,
  input  wire logic [2*CW-1:0]           mag_i,
  input  wire logic [((2*CW+1 > dcr_pkg::LIMIT_W) ? 2*CW+1 : dcr_pkg::LIMIT_W)+F:0] num_i,
  input  wire logic [((2*CW+1 > dcr_pkg::LIMIT_W) ? 2*CW+1 : dcr_pkg::LIMIT_W)+1:0] den_i,
  input  wire dcr_pkg::ctl_t             ctl_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic [4*CW-1:0]                crd_o,
  output logic [dcr_pkg::CASE_W-1:0]     kind_o,
  output logic                           clip_o
);
  import dcr_pkg::*;

  localparam int SW = (2*CW+1 > LIMIT_W) ? 2*CW+1 : LIMIT_W;
  localparam int NW = SW + F + 1;
  localparam int DW = SW + 2;
  localparam int RW = SW + 3;
  localparam int QW = F + 1;
  localparam int PW = QW + CW;
  localparam int EW = CW + 3;
  localparam int NS = QW + 4;

  localparam logic [PW:0] HALF = (PW+1)'(1) << (F-1);
  localparam logic signed [EW-1:0] CMAX = {{(EW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [EW-1:0] CMIN = ~CMAX;

  logic          en;
  logic [NS-1:0] v_r;

  logic [RW-1:0]   r_r   [0:QW-1];
  logic [DW-1:0]   den_r [0:QW-1];
  logic [QW-1:0]   lo_r  [0:QW];
  logic [4*CW-1:0] crd_r [0:QW];
  logic [2*CW-1:0] mag_r [0:QW];
  ctl_t            ctl_r [0:QW];

  logic [RW-1:0]   t_c  [0:QW-1];
  logic [RW-1:0]   rn_c [0:QW-1];
  logic            ge_c [0:QW-1];

  logic [QW-1:0]   s_c;
  logic [PW-1:0]   pxm_r, pym_r;
  logic [4*CW-1:0] crdm_r, crdr_r, crdo_r;
  ctl_t            ctlm_r;
  logic [CASE_W-1:0] kindr_r, kindo_r;

  logic [PW:0]     sumx_c, sumy_c;
  logic signed [EW-1:0] mex_c, mey_c;
  logic signed [EW-1:0] mvx_r, mvy_r;

  logic signed [EW-1:0] ax_c, ay_c, bx_c, by_c;
  logic [CW:0]     sax_c, say_c, sbx_c, sby_c;
  logic            clipo_r;

  assign en    = out_ready_i || !v_r[NS-1];
  assign pop_o = en && in_valid_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NS-2:0], in_valid_i};
    end
  end

  always_comb begin
    for (int k = 0; k < QW; k++) begin
      t_c[k]  = {r_r[k][RW-2:0], lo_r[k][QW-1]};
      ge_c[k] = t_c[k] >= RW'(den_r[k]);
      rn_c[k] = ge_c[k] ? (t_c[k] - RW'(den_r[k])) : t_c[k];
    end
  end

  // quotient bits enter lo from the bottom as dividend bits leave the top
  always_ff @(posedge clk) begin
    if (en) begin
      r_r[0]   <= RW'(num_i[NW-1:QW]);
      den_r[0] <= den_i;
      lo_r[0]  <= num_i[QW-1:0];
      crd_r[0] <= crd_i;
      mag_r[0] <= mag_i;
      ctl_r[0] <= ctl_i;
      for (int k = 0; k < QW-1; k++) begin
        r_r[k+1]   <= rn_c[k];
        den_r[k+1] <= den_r[k];
      end
      for (int k = 0; k < QW; k++) begin
        lo_r[k+1]  <= {lo_r[k][QW-2:0], ge_c[k]};
        crd_r[k+1] <= crd_r[k];
        mag_r[k+1] <= mag_r[k];
        ctl_r[k+1] <= ctl_r[k];
      end
    end
  end

  assign s_c = (ctl_r[QW].kind == CASE_BAND) ? '0 : lo_r[QW];

  always_comb begin
    sumx_c = (PW+1)'(pxm_r) + HALF;
    sumy_c = (PW+1)'(pym_r) + HALF;
    mex_c  = EW'(sumx_c[PW:F]);
    mey_c  = EW'(sumy_c[PW:F]);
  end

  function automatic logic [CW:0] sat_f(input logic signed [EW-1:0] v);
    if (v > CMAX) begin
      return {1'b1, CMAX[CW-1:0]};
    end else if (v < CMIN) begin
      return {1'b1, CMIN[CW-1:0]};
    end else begin
      return {1'b0, v[CW-1:0]};
    end
  endfunction

  always_comb begin
    ax_c  = {{(EW-CW){crdr_r[CW-1]}},   crdr_r[CW-1:0]}      - mvx_r;
    ay_c  = {{(EW-CW){crdr_r[2*CW-1]}}, crdr_r[2*CW-1:CW]}   - mvy_r;
    bx_c  = {{(EW-CW){crdr_r[3*CW-1]}}, crdr_r[3*CW-1:2*CW]} + mvx_r;
    by_c  = {{(EW-CW){crdr_r[4*CW-1]}}, crdr_r[4*CW-1:3*CW]} + mvy_r;
    sax_c = sat_f(ax_c);
    say_c = sat_f(ay_c);
    sbx_c = sat_f(bx_c);
    sby_c = sat_f(by_c);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pxm_r  <= PW'(s_c) * PW'(mag_r[QW][CW-1:0]);
      pym_r  <= PW'(s_c) * PW'(mag_r[QW][2*CW-1:CW]);
      crdm_r <= crd_r[QW];
      ctlm_r <= ctl_r[QW];

      mvx_r   <= ctlm_r.neg_x ? (EW'(0) - mex_c) : mex_c;
      mvy_r   <= ctlm_r.neg_y ? (EW'(0) - mey_c) : mey_c;
      crdr_r  <= crdm_r;
      kindr_r <= ctlm_r.kind;

      crdo_r  <= {sby_c[CW-1:0], sbx_c[CW-1:0], say_c[CW-1:0], sax_c[CW-1:0]};
      clipo_r <= sax_c[CW] | say_c[CW] | sbx_c[CW] | sby_c[CW];
      kindo_r <= kindr_r;
    end
  end

  assign out_valid_o = v_r[NS-1];
  assign crd_o       = crdo_r;
  assign kind_o      = kindo_r;
  assign clip_o      = clipo_r;

  `DCR_ASSERT(a_band_no_clip, clk, rst_n, (v_r[NS-1] && kindo_r == CASE_BAND) |-> !clipo_r, "clip in band case")
  `DCR_NEVER(a_kind_code, clk, rst_n, v_r[NS-1] && kindo_r == 2'd3, "unused case code at output")
  `DCR_ASSERT(a_hold_stall, clk, rst_n, (v_r[NS-1] && !out_ready_i) |=> (v_r[NS-1] && $stable(crdo_r)), "result lost under stall")

endmodule

`default_nettype wire

FILE: hw/rtl/distance_constraint_relax.sv
// Top level of the distance constraint relax block: limit registers, front, queue, back.
// Depends on dcr_pkg, dcr_front, dcr_queue and dcr_back.
//
//   port group   dir   role
//   in_*         in    joint end points a and b, one joint per beat
//   out_*        out   relaxed end points, case and clip flags, one beat per joint
//   cfg_*        in    short and long squared length limits
//
// One joint per cycle sustained while out_tready is high; the restoring divider resolves
// one quotient bit per stage.
// rst_n is synchronous and clears the limits, stage valids and queue pointers.
// out_tready low freezes the back pipeline; the four entry queue then fills and
// in_tready falls once it is full with the front pipeline's last stage occupied.
`default_nettype none

module distance_constraint_relax #(
  parameter int COORD_WIDTH     = 16,
  parameter int SCALE_FRAC_BITS = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // a_x, a_y, b_x, b_y
  input  wire logic [((4*COORD_WIDTH+7)/8)*8-1:0] in_tdata,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // new_a_x, new_a_y, new_b_x, new_b_y
  output logic [((4*COORD_WIDTH+7)/8)*8-1:0]     out_tdata,
  // case_taken, clipped
  output logic [2:0]                             out_tuser,
  input  wire logic                              cfg_wen,
  input  wire logic [dcr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [dcr_pkg::LIMIT_W-1:0]       cfg_wdata
);
  import dcr_pkg::*;

  localparam int CW = COORD_WIDTH;
  localparam int F  = SCALE_FRAC_BITS;
  localparam int SW = (2*CW+1 > LIMIT_W) ? 2*CW+1 : LIMIT_W;
  localparam int NW = SW + F + 1;
  localparam int DW = SW + 2;
  localparam int TW = ((4*CW+7)/8)*8;
  localparam int CT = $bits(ctl_t);
  localparam int QW_ITEM = 4*CW + 2*CW + NW + DW + CT;

  logic [LIMIT_W-1:0] short_r, long_r;

  logic            f_valid, q_full, q_empty, push, pop;
  logic [4*CW-1:0] f_crd, b_crd;
  logic [2*CW-1:0] f_mag;
  logic [NW-1:0]   f_num;
  logic [DW-1:0]   f_den;
  ctl_t            f_ctl;
  logic [QW_ITEM-1:0] q_in, q_out;
  logic [CASE_W-1:0]  b_kind;
  logic               b_clip;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      short_r <= '0;
      long_r  <= '0;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        CFG_SHORT: short_r <= cfg_wdata;
        CFG_LONG:  long_r  <= cfg_wdata;
      endcase
    end
  end

  dcr_front #(.CW(CW), .F(F)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid_i  (in_tvalid),
    .in_ready_o  (in_tready),
    .a_x_i       (in_tdata[CW-1:0]),
    .a_y_i       (in_tdata[2*CW-1:CW]),
    .b_x_i       (in_tdata[3*CW-1:2*CW]),
    .b_y_i       (in_tdata[4*CW-1:3*CW]),
    .short_i     (short_r),
    .long_i      (long_r),
    .out_valid_o (f_valid),
    .out_ready_i (!q_full),
    .crd_o       (f_crd),
    .mag_o       (f_mag),
    .num_o       (f_num),
    .den_o       (f_den),
    .ctl_o       (f_ctl)
  );

  assign push = f_valid && !q_full;
  assign q_in = {f_ctl, f_den, f_num, f_mag, f_crd};

  dcr_queue #(.W(QW_ITEM)) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (push),
    .data_i  (q_in),
    .pop_i   (pop),
    .data_o  (q_out),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  dcr_back #(.CW(CW), .F(F)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid_i  (!q_empty),
    .pop_o       (pop),
    .crd_i       (q_out[4*CW-1:0]),
    .mag_i       (q_out[6*CW-1:4*CW]),
    .num_i       (q_out[6*CW+NW-1:6*CW]),
    .den_i       (q_out[6*CW+NW+DW-1:6*CW+NW]),
    .ctl_i       (q_out[QW_ITEM-1:6*CW+NW+DW]),
    .out_valid_o (out_tvalid),
    .out_ready_i (out_tready),
    .crd_o       (b_crd),
    .kind_o      (b_kind),
    .clip_o      (b_clip)
  );

  assign out_tdata = TW'(b_crd);
  assign out_tuser = {b_clip, b_kind};

endmodule

`default_nettype wire

FILE: bench/dcr_checker.sv
// Scoreboard for distance_constraint_relax: mirrors the limit registers, predicts each
// relaxed joint from the input beats and compares the result beats in order.
// Depends on dcr_pkg for the register indexes and case codes.
module dcr_checker #(
  parameter int COORD_W = 16,
  parameter int SCALE_F = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  input  logic                        in_tready,
  input  logic [63:0]                 in_tdata,
  input  logic                        out_tvalid,
  input  logic                        out_tready,
  input  logic [63:0]                 out_tdata,
  input  logic [2:0]                  out_tuser,
  input  logic                        cfg_wen,
  input  logic [dcr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dcr_pkg::LIMIT_W-1:0] cfg_wdata,
  output int                          fail_count,
  output int                          pending
);
  import dcr_pkg::*;

  localparam longint COORD_MAX = (64'sd1 <<< (COORD_W - 1)) - 1;
  localparam longint COORD_MIN = -COORD_MAX - 1;

  typedef struct packed {
    logic [15:0]       ax;
    logic [15:0]       ay;
    logic [15:0]       bx;
    logic [15:0]       by;
    logic [CASE_W-1:0] kind;
    logic              clip;
  } joint_res_t;

  longint unsigned short_lim;
  longint unsigned long_lim;
  joint_res_t      relaxed_q[$];

  initial begin
    fail_count = 0;
    pending    = 0;
    short_lim  = 0;
    long_lim   = 0;
  end

  function automatic longint unsigned abs_val(longint v);
    return v < 0 ? longint'(-v) : v;
  endfunction

  // round(s * v / 2^F), halves away from zero
  function automatic longint move_by_scale(longint unsigned s_mag, logic s_neg, longint v);
    longint unsigned p;
    longint unsigned m;
    p = s_mag * abs_val(v);
    m = (p + (64'd1 << (SCALE_F - 1))) >> SCALE_F;
    return (s_neg != (v < 0)) ? -longint'(m) : longint'(m);
  endfunction

  // {clipped, value}
  function automatic logic [16:0] clamp_coord(longint v);
    if (v > COORD_MAX) return {1'b1, 16'(COORD_MAX)};
    if (v < COORD_MIN) return {1'b1, 16'(COORD_MIN)};
    return {1'b0, 16'(v)};
  endfunction

  function automatic joint_res_t relax_joint(logic [63:0] beat);
    longint          ax, ay, bx, by, dx, dy, movx, movy;
    longint unsigned d, lim, num, den, s_mag;
    logic            s_neg, c;
    joint_res_t      r;
    ax = longint'($signed(beat[15:0]));
    ay = longint'($signed(beat[31:16]));
    bx = longint'($signed(beat[47:32]));
    by = longint'($signed(beat[63:48]));
    dx = bx - ax;
    dy = by - ay;
    d  = longint'(dx * dx + dy * dy);
    r.ax   = beat[15:0];
    r.ay   = beat[31:16];
    r.bx   = beat[47:32];
    r.by   = beat[63:48];
    r.kind = CASE_BAND;
    r.clip = 1'b0;
    lim    = 0;
    if (d < short_lim) begin
      r.kind = CASE_SHORT;
      lim    = short_lim;
    end else if (d > long_lim) begin
      r.kind = CASE_LONG;
      lim    = long_lim;
    end
    if (r.kind != CASE_BAND) begin
      s_neg = lim < d;
      num   = s_neg ? d - lim : lim - d;
      den   = 64'd2 * (d + lim);
      s_mag = ((num << SCALE_F) + den / 64'd2) / den;
      movx  = move_by_scale(s_mag, s_neg, dx);
      movy  = move_by_scale(s_mag, s_neg, dy);
      {c, r.ax} = clamp_coord(ax - movx);
      r.clip |= c;
      {c, r.ay} = clamp_coord(ay - movy);
      r.clip |= c;
      {c, r.bx} = clamp_coord(bx + movx);
      r.clip |= c;
      {c, r.by} = clamp_coord(by + movy);
      r.clip |= c;
    end
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t: %s", $time, msg);
    fail_count++;
  endtask

  task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %h want %h", name, got, want));
  endtask

  always @(posedge clk) begin
    joint_res_t want;
    if (!rst_n) begin
      short_lim = 0;
      long_lim  = 0;
      relaxed_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (relaxed_q.size() == 0) begin
          report_mismatch($sformatf("result beat %h/%h with nothing expected",
                                    out_tdata, out_tuser));
        end else begin
          want = relaxed_q.pop_front();
          check_field("new_a_x", out_tdata[15:0], want.ax);
          check_field("new_a_y", out_tdata[31:16], want.ay);
          check_field("new_b_x", out_tdata[47:32], want.bx);
          check_field("new_b_y", out_tdata[63:48], want.by);
          check_field("case_taken", 16'(out_tuser[1:0]), 16'(want.kind));
          check_field("clipped", 16'(out_tuser[2]), 16'(want.clip));
        end
      end
      if (in_tvalid && in_tready)
        relaxed_q.push_back(relax_joint(in_tdata));
      if (cfg_wen) begin
        if (cfg_index == CFG_SHORT)
          short_lim = 64'(cfg_wdata);
        else if (cfg_index == CFG_LONG)
          long_lim = 64'(cfg_wdata);
      end
    end
    pending = relaxed_q.size();
  end

endmodule

FILE: bench/testbench.sv
// Top of the distance_constraint_relax bench: clock, reset, limit writes, joint stimulus
// and result back-pressure; checking is done by dcr_checker.
// Depends on dcr_pkg, dcr_checker and the distance_constraint_relax RTL.
module testbench;
  import dcr_pkg::*;

  localparam int SCALE_F  = 16;
  localparam int LATENCY  = SCALE_F + 10;
  localparam int HOLD_CYC = 300;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [63:0]          in_tdata = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [63:0]          out_tdata;
  logic [2:0]           out_tuser;
  logic                 cfg_wen = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_SHORT;
  logic [LIMIT_W-1:0]   cfg_wdata = '0;

  int fail_count;
  int pending;
  bit idle_on  = 1'b1;
  bit hold_req = 1'b0;
  int rad_short;
  int rad_long;

  distance_constraint_relax dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  dcr_checker #(.COORD_W(16), .SCALE_F(SCALE_F)) chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .fail_count(fail_count),
    .pending   (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // result side back-pressure
  initial begin
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYC) @(posedge clk);
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  task automatic send_joint(logic [15:0] ax, logic [15:0] ay, logic [15:0] bx,
                            logic [15:0] by);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_tdata  <= {by, bx, ay, ax};
    in_tvalid <= 1'b1;
    do @(negedge clk); while (!in_tready);
    @(posedge clk);
  endtask

  // drain: input idle until every result is back, then a further idle wait
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    do @(negedge clk); while (pending != 0);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_limits(logic [LIMIT_W-1:0] short_sq, logic [LIMIT_W-1:0] long_sq);
    wait_idle();
    cfg_wen   <= 1'b1;
    cfg_index <= CFG_SHORT;
    cfg_wdata <= short_sq;
    @(posedge clk);
    cfg_index <= CFG_LONG;
    cfg_wdata <= long_sq;
    @(posedge clk);
    cfg_wen   <= 1'b0;
  endtask

  task automatic send_random_joint();
    logic [15:0] ax, ay;
    int          r, dx, dy;
    ax = 16'($urandom());
    ay = 16'($urandom());
    case ($urandom_range(0, 9))
      0: begin
        send_joint(ax, ay, 16'($urandom()), 16'($urandom()));
        return;
      end
      1, 2: begin
        r  = $urandom_range(0, 8);
        dx = $urandom_range(0, 2 * r) - r;
        dy = $urandom_range(0, 2 * r) - r;
      end
      3, 4, 5: begin
        // near the short limit
        r  = rad_short + $urandom_range(0, 4) - 2;
        dx = ($urandom_range(0, 1) ? r : -r);
        dy = $urandom_range(0, 4) - 2;
      end
      6, 7: begin
        r  = rad_long + $urandom_range(0, 4) - 2;
        dy = ($urandom_range(0, 1) ? r : -r);
        dx = $urandom_range(0, 4) - 2;
      end
      8: begin
        dx = $urandom_range(0, 65535) - 32768;
        dy = $urandom_range(0, 65535) - 32768;
      end
      default: begin
        // end points near the coordinate extremes
        ax = $urandom_range(0, 1) ? 16'h7fff - 16'($urandom_range(0, 60))
                                  : 16'h8000 + 16'($urandom_range(0, 60));
        ay = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
        dx = $urandom_range(0, 400) - 200;
        dy = $urandom_range(0, 400) - 200;
      end
    endcase
    send_joint(ax, ay, ax + 16'(dx), ay + 16'(dy));
  endtask

  initial begin
    longint sq_short, sq_long;
    int     mode;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // band of 1000..3000 raw units
    write_limits(33'd1_000_000, 33'd9_000_000);
    send_joint(16'd0, 16'd0, 16'd0, 16'd0);
    send_joint(16'h8000, 16'h8000, 16'h7fff, 16'h7fff);
    send_joint(16'h7fff, 16'h7fff, 16'h8000, 16'h8000);
    send_joint(16'h7fff, 16'd0, 16'h7f9b, 16'd0);
    send_joint(16'h8000, 16'h8000, 16'h8064, 16'h8000);
    send_joint(16'd0, 16'd0, 16'd1000, 16'd0);
    send_joint(16'd0, 16'd0, 16'd999, 16'd0);
    send_joint(16'd0, 16'd0, 16'd3000, 16'd0);
    send_joint(16'd0, 16'd0, 16'd3000, 16'd1);
    send_joint(16'd100, -16'sd200, -16'sd1900, -16'sd200);
    send_joint(-16'sd5, 16'd7, -16'sd5, 16'd8);

    // inverted limits: short test wins where both are crossed
    write_limits(33'd9_000_000, 33'd1_000_000);
    send_joint(16'd0, 16'd0, 16'd2000, 16'd0);
    send_joint(16'd0, 16'd0, 16'd0, -16'sd4000);
    send_joint(16'd0, 16'd0, 16'd500, 16'd500);

    write_limits('0, '0);
    send_joint(16'd1234, -16'sd4321, 16'd1234, -16'sd4321);
    send_joint(16'd0, 16'd0, 16'd0, 16'd1);
    send_joint(16'h8000, 16'h7fff, 16'h7fff, 16'h8000);

    write_limits('1, '1);
    send_joint(16'h8000, 16'h8000, 16'h7fff, 16'h7fff);
    send_joint(16'd7, 16'd7, 16'd7, 16'd7);

    for (int ph = 0; ph < 12; ph++) begin
      mode      = ph % 6;
      idle_on   = (ph < 10);
      rad_short = $urandom_range(0, 4000);
      rad_long  = rad_short + $urandom_range(0, 20000);
      sq_short  = longint'(rad_short) * rad_short;
      sq_long   = longint'(rad_long) * rad_long;
      case (mode)
        0: write_limits(33'(sq_short), 33'(sq_long));
        1: write_limits(33'(sq_long), 33'(sq_short));
        2: write_limits('0, '0);
        3: write_limits('1, '1);
        4: write_limits(33'({$urandom(), $urandom()}), 33'({$urandom(), $urandom()}));
        default: write_limits('0, 33'(sq_long));
      endcase
      if (ph == 2) begin
        // long receiver stall while beats keep coming; then drain fully
        hold_req = 1'b1;
        repeat (60) send_random_joint();
        wait_idle();
      end
      repeat (158) send_random_joint();
    end

    wait_idle();
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/dcr_pkg.sv
hw/rtl/dcr_front.sv
hw/rtl/dcr_queue.sv
hw/rtl/dcr_back.sv
hw/rtl/distance_constraint_relax.sv
bench/dcr_checker.sv
bench/testbench.sv
